// ===== hw/rtl/rmst_pkg.sv =====
// package for the range minimum segment tree
// sizes, the empty value, command codes and the controller states; no dependencies
`default_nettype none

package rmst_pkg;

  // tree geometry, leaf count rounded up to a power of two
  localparam int unsigned LEAVES     = 1024;
  localparam int unsigned TREE_SPAN  = 1 << $clog2(LEAVES);
  localparam int unsigned NODE_COUNT = 2 * TREE_SPAN;
  // node index width and a one bit wider walker index
  localparam int unsigned IDX_W      = $clog2(NODE_COUNT);
  localparam int unsigned ADDR_W     = IDX_W + 1;

  // word field widths
  localparam int unsigned POS_W = 11;
  localparam int unsigned VAL_W = 30;

  localparam logic [VAL_W-1:0] EMPTY_VALUE = VAL_W'(1000000000);

  typedef enum logic {
    CMD_UPDATE = 1'b0,
    CMD_QUERY  = 1'b1
  } cmd_e;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_U_UP,
    ST_Q_LOOP,
    ST_Q_DONE
  } state_e;

endpackage

`default_nettype wire

// ===== hw/rtl/range_min_segment_tree.sv =====
// Range minimum segment tree: node memory, update walk and query walk
// A tree of NODE_COUNT entries is held in one synchronous RAM; the sizing and codes
// come from rmst_pkg.
//
// After reset the block sweeps all NODE_COUNT (2048) entries of the node memory to
// the empty value, one entry a cycle, and holds in_stall_o high meanwhile. It then
// takes one word at a time. An update writes the leaf and climbs to the root with
// one sibling read per level on the single RAM read port; a position of 0 or beyond
// the leaf count is ignored. A query walks both range borders up the tree, one RAM
// read or one level step per cycle, then hands the result to the output register
// once that register is free. Updates give no result word; a query gives one.
// The output register lets the next word enter while a result waits to be taken.
`default_nettype none

module range_min_segment_tree
  import rmst_pkg::*;
(
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             in_valid_i,
  output logic                  in_stall_o,
  input  wire logic             command_i,
  input  wire logic [POS_W-1:0] position_i,
  input  wire logic [VAL_W-1:0] new_value_i,
  input  wire logic [POS_W-1:0] range_low_i,
  input  wire logic [POS_W-1:0] range_high_i,
  output logic                  out_valid_o,
  input  wire logic             out_stall_i,
  output logic [VAL_W-1:0]      minimum_o
);

  state_e            state_q, state_d;
  logic [IDX_W-1:0]  node_q, node_d;
  logic [IDX_W-1:0]  clr_q, clr_d;
  logic [VAL_W-1:0]  cur_q, cur_d;
  logic [VAL_W-1:0]  res_q, res_d;
  logic [ADDR_W-1:0] a_q, a_d;
  logic [ADDR_W-1:0] b_q, b_d;
  logic              out_valid_q, out_valid_d;
  logic [VAL_W-1:0]  min_q, min_d;
  logic              rd_valid_q;
  logic [VAL_W-1:0]  rdata_q;

  logic [VAL_W-1:0]  mem [NODE_COUNT];

  logic              mem_we;
  logic [IDX_W-1:0]  mem_waddr;
  logic [VAL_W-1:0]  mem_wdata;
  logic              mem_re;
  logic [IDX_W-1:0]  mem_raddr;

  logic [VAL_W-1:0]  sat_value;
  logic [IDX_W-1:0]  leaf_idx;
  logic              pos_ok;
  logic [ADDR_W-1:0] lo_c, hi_c;
  logic [VAL_W-1:0]  fold;
  logic [VAL_W-1:0]  up_min;
  logic [IDX_W-1:0]  parent;
  logic [ADDR_W-1:0] a_inc, b_dec;

  assign in_stall_o  = (state_q != ST_IDLE);
  assign out_valid_o = out_valid_q;
  assign minimum_o   = min_q;

  // word decode for update and query
  always_comb begin
    sat_value = (new_value_i > EMPTY_VALUE) ? EMPTY_VALUE : new_value_i;
    pos_ok    = (position_i != '0) && (32'(position_i) <= LEAVES);
    leaf_idx  = IDX_W'(32'(position_i) + TREE_SPAN - 1);
    lo_c      = (range_low_i == '0) ? ADDR_W'(1) : ADDR_W'(range_low_i);
    hi_c      = (32'(range_high_i) > TREE_SPAN + 1) ? ADDR_W'(TREE_SPAN + 1)
                                                   : ADDR_W'(range_high_i);
  end

  // walk helpers
  always_comb begin
    fold   = (rd_valid_q && (rdata_q < res_q)) ? rdata_q : res_q;
    up_min = (rdata_q < cur_q) ? rdata_q : cur_q;
    parent = node_q >> 1;
    a_inc  = a_q + ADDR_W'(1);
    b_dec  = b_q - ADDR_W'(1);
  end

  // next state, memory control and output register
  always_comb begin
    state_d     = state_q;
    node_d      = node_q;
    clr_d       = clr_q;
    cur_d       = cur_q;
    res_d       = res_q;
    a_d         = a_q;
    b_d         = b_q;
    out_valid_d = out_valid_q;
    min_d       = min_q;
    mem_we      = 1'b0;
    mem_waddr   = clr_q;
    mem_wdata   = EMPTY_VALUE;
    mem_re      = 1'b0;
    mem_raddr   = '0;

    if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end

    unique case (state_q)
      ST_CLEAR: begin
        mem_we    = 1'b1;
        mem_waddr = clr_q;
        clr_d     = clr_q + IDX_W'(1);
        if (clr_q == IDX_W'(NODE_COUNT - 1)) begin
          state_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (in_valid_i) begin
          if (command_i == CMD_UPDATE) begin
            if (pos_ok) begin
              mem_we    = 1'b1;
              mem_waddr = leaf_idx;
              mem_wdata = sat_value;
              cur_d     = sat_value;
              node_d    = leaf_idx;
              mem_re    = 1'b1;
              mem_raddr = leaf_idx ^ IDX_W'(1);
              state_d   = ST_U_UP;
            end
          end else begin
            res_d = EMPTY_VALUE;
            if (lo_c < hi_c) begin
              a_d     = lo_c + ADDR_W'(TREE_SPAN - 1);
              b_d     = hi_c + ADDR_W'(TREE_SPAN - 1);
              state_d = ST_Q_LOOP;
            end else begin
              state_d = ST_Q_DONE;
            end
          end
        end
      end
      // sibling data is back: write the parent, fetch its sibling unless it is the root
      ST_U_UP: begin
        mem_we    = 1'b1;
        mem_waddr = parent;
        mem_wdata = up_min;
        cur_d     = up_min;
        node_d    = parent;
        if (parent == IDX_W'(1)) begin
          state_d = ST_IDLE;
        end else begin
          mem_re    = 1'b1;
          mem_raddr = parent ^ IDX_W'(1);
        end
      end
      // border walk, reading the border nodes that leave the range, folding the previous read
      ST_Q_LOOP: begin
        res_d = fold;
        if (a_q < b_q) begin
          if (a_q[0]) begin
            mem_re    = 1'b1;
            mem_raddr = a_q[IDX_W-1:0];
            if (b_q[0]) begin
              a_d = a_inc;
            end else begin
              a_d = a_inc >> 1;
              b_d = b_q >> 1;
            end
          end else if (b_q[0]) begin
            mem_re    = 1'b1;
            mem_raddr = b_dec[IDX_W-1:0];
            a_d       = a_q >> 1;
            b_d       = b_dec >> 1;
          end else begin
            a_d = a_q >> 1;
            b_d = b_q >> 1;
          end
        end else begin
          state_d = ST_Q_DONE;
        end
      end
      ST_Q_DONE: begin
        if (!out_valid_q || !out_stall_i) begin
          out_valid_d = 1'b1;
          min_d       = res_q;
          state_d     = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_CLEAR;
      clr_q       <= '0;
      out_valid_q <= 1'b0;
      rd_valid_q  <= 1'b0;
    end else begin
      state_q     <= state_d;
      clr_q       <= clr_d;
      out_valid_q <= out_valid_d;
      rd_valid_q  <= mem_re;
    end
  end

  // datapath registers
  always_ff @(posedge clk_i) begin
    node_q <= node_d;
    cur_q  <= cur_d;
    res_q  <= res_d;
    a_q    <= a_d;
    b_q    <= b_d;
    min_q  <= min_d;
  end

  // node memory, one write and one registered read port
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    if (mem_re) begin
      rdata_q <= mem[mem_raddr];
    end
  end

  // a result word only comes out of the query finish state
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(state_q) == ST_Q_DONE)
    else $error("result word without finished query");

  // each climb step needs the sibling read of the cycle before
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_U_UP |-> rd_valid_q)
    else $error("update climb without sibling data");

  // the border walk stays inside the tree
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_Q_LOOP |-> (b_q <= ADDR_W'(NODE_COUNT)))
    else $error("query border beyond node memory");

  // results never exceed the empty value
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> minimum_o <= EMPTY_VALUE)
    else $error("minimum above empty value");

endmodule

`default_nettype wire

// ===== dv/tb_range_min_segment_tree.sv =====
// testbench for range_min_segment_tree: directed and random update and query words against a
// leaf-array model of the range minimum; depends on rmst_pkg and the block's rtl
`timescale 1ns / 1ps

module tb_range_min_segment_tree;
  import rmst_pkg::*;

  typedef struct packed {
    cmd_e             command;
    logic [POS_W-1:0] position;
    logic [VAL_W-1:0] new_value;
    logic [POS_W-1:0] range_low;
    logic [POS_W-1:0] range_high;
  } tree_word_t;

  logic             clk_i        = 1'b0;
  logic             rst_ni       = 1'b0;
  logic             in_valid_i   = 1'b0;
  logic             in_stall_o;
  logic             command_i    = 1'b0;
  logic [POS_W-1:0] position_i   = '0;
  logic [VAL_W-1:0] new_value_i  = '0;
  logic [POS_W-1:0] range_low_i  = '0;
  logic [POS_W-1:0] range_high_i = '0;
  logic             out_valid_o;
  logic             out_stall_i  = 1'b0;
  logic [VAL_W-1:0] minimum_o;

  tree_word_t       pending_words[$];
  logic [VAL_W-1:0] expected_minima[$];
  logic [VAL_W-1:0] leaf_values[1:TREE_SPAN];
  int unsigned      sent_words = 0;
  int unsigned      error_count = 0;
  logic             steady;

  range_min_segment_tree dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .command_i    (command_i),
    .position_i   (position_i),
    .new_value_i  (new_value_i),
    .range_low_i  (range_low_i),
    .range_high_i (range_high_i),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .minimum_o    (minimum_o)
  );

  // clock
  always begin
    clk_i = 1'b0;
    #6;
    clk_i = 1'b1;
    #6;
  end

  // a stretch of words with no idling on either side
  assign steady = (sent_words >= 600) && (sent_words < 900);

  // least leaf value over [low, high), clipped to the tree
  function automatic logic [VAL_W-1:0] span_minimum(logic [POS_W-1:0] low,
                                                    logic [POS_W-1:0] high);
    int unsigned      lo;
    int unsigned      hi;
    logic [VAL_W-1:0] least;
    lo    = (low < 1) ? 1 : low;
    hi    = (high > TREE_SPAN + 1) ? TREE_SPAN + 1 : high;
    least = EMPTY_VALUE;
    for (int unsigned p = lo; p < hi; p++) begin
      if (leaf_values[p] < least) least = leaf_values[p];
    end
    return least;
  endfunction

  // apply one accepted word to the leaf model
  task automatic track_word(tree_word_t w);
    if (w.command == CMD_QUERY) begin
      expected_minima.push_back(span_minimum(w.range_low, w.range_high));
    end else if (w.position >= 1 && w.position <= LEAVES) begin
      leaf_values[w.position] = (w.new_value > EMPTY_VALUE) ? EMPTY_VALUE : w.new_value;
    end
  endtask

  function automatic tree_word_t make_word(cmd_e cmd, int unsigned pos, int unsigned val,
                                           int unsigned lo, int unsigned hi);
    tree_word_t w;
    w.command    = cmd;
    w.position   = POS_W'(pos);
    w.new_value  = VAL_W'(val);
    w.range_low  = POS_W'(lo);
    w.range_high = POS_W'(hi);
    return w;
  endfunction

  // random word: mostly in-range updates and queries, some noise
  function automatic tree_word_t random_word();
    tree_word_t  w;
    int unsigned pick;
    int unsigned lo;
    int unsigned hi;
    w.command    = cmd_e'($urandom_range(0, 1));
    w.position   = POS_W'($urandom());
    w.new_value  = VAL_W'($urandom());
    w.range_low  = POS_W'($urandom());
    w.range_high = POS_W'($urandom());
    pick = $urandom_range(0, 99);
    if (pick < 45) begin
      w.command  = CMD_UPDATE;
      w.position = POS_W'($urandom_range(1, LEAVES));
      case ($urandom_range(0, 3))
        0: w.new_value = VAL_W'($urandom_range(0, 50));
        1: w.new_value = VAL_W'($urandom_range(0, 100000));
        2: w.new_value = EMPTY_VALUE - VAL_W'($urandom_range(0, 20));
        default: ;
      endcase
    end else if (pick < 90) begin
      w.command = CMD_QUERY;
      lo = $urandom_range(1, LEAVES);
      if ($urandom_range(0, 1)) begin
        hi = lo + $urandom_range(0, 16);
        if (hi > LEAVES + 1) hi = LEAVES + 1;
      end else begin
        hi = $urandom_range(lo, LEAVES + 1);
      end
      w.range_low  = POS_W'(lo);
      w.range_high = POS_W'(hi);
    end
    return w;
  endfunction

  // driver: present queued words, track accepted ones
  always @(posedge clk_i or negedge rst_ni) begin
    tree_word_t w;
    if (!rst_ni) begin
      in_valid_i   <= 1'b0;
      command_i    <= 1'b0;
      position_i   <= '0;
      new_value_i  <= '0;
      range_low_i  <= '0;
      range_high_i <= '0;
    end else begin
      if (in_valid_i && !in_stall_o) begin
        track_word(make_word(cmd_e'(command_i), position_i, new_value_i,
                             range_low_i, range_high_i));
      end
      if (!in_valid_i || !in_stall_o) begin
        if (pending_words.size() > 0 && (steady || $urandom_range(0, 99) >= 6)) begin
          w = pending_words.pop_front();
          in_valid_i   <= 1'b1;
          command_i    <= w.command;
          position_i   <= w.position;
          new_value_i  <= w.new_value;
          range_low_i  <= w.range_low;
          range_high_i <= w.range_high;
          sent_words   <= sent_words + 1;
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  // monitor: check each result word against the oldest expectation
  always @(posedge clk_i or negedge rst_ni) begin
    logic [VAL_W-1:0] want;
    if (!rst_ni) begin
      out_stall_i <= 1'b0;
    end else begin
      if (out_valid_o && !out_stall_i) begin
        if (expected_minima.size() == 0) begin
          $display("%0t: unexpected result word, expected none, actual %0d",
                   $time, minimum_o);
          error_count++;
        end else begin
          want = expected_minima.pop_front();
          if (minimum_o !== want) begin
            $display("%0t: minimum mismatch, expected %0d, actual %0d",
                     $time, want, minimum_o);
            error_count++;
          end
        end
      end
      out_stall_i <= !steady && ($urandom_range(0, 99) < 6);
    end
  end

  // stimulus and end of run
  initial begin
    for (int unsigned p = 1; p <= TREE_SPAN; p++) leaf_values[p] = EMPTY_VALUE;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;

    // directed: empty tree, ignored updates, saturation, clipped and empty ranges
    pending_words.push_back(make_word(CMD_QUERY,  0, 0, 1, LEAVES + 1));
    pending_words.push_back(make_word(CMD_UPDATE, 0, 5, 0, 0));
    pending_words.push_back(make_word(CMD_UPDATE, LEAVES + 1, 6, 0, 0));
    pending_words.push_back(make_word(CMD_UPDATE, 2047, 7, 2047, 2047));
    pending_words.push_back(make_word(CMD_QUERY,  0, 0, 0, 2047));
    pending_words.push_back(make_word(CMD_UPDATE, 1, 0, 0, 0));
    pending_words.push_back(make_word(CMD_UPDATE, LEAVES, 1234, 0, 0));
    pending_words.push_back(make_word(CMD_UPDATE, 512, 30'h3FFF_FFFF, 0, 0));
    pending_words.push_back(make_word(CMD_UPDATE, 513, 1000000000, 0, 0));
    pending_words.push_back(make_word(CMD_QUERY,  0, 0, 512, 514));
    pending_words.push_back(make_word(CMD_QUERY,  0, 0, 0, 2047));
    pending_words.push_back(make_word(CMD_QUERY,  0, 0, 2, LEAVES + 1));
    pending_words.push_back(make_word(CMD_QUERY,  0, 0, LEAVES, LEAVES + 1));
    pending_words.push_back(make_word(CMD_QUERY,  0, 0, 1, 2));
    pending_words.push_back(make_word(CMD_QUERY,  0, 0, 5, 5));
    pending_words.push_back(make_word(CMD_QUERY,  0, 0, 10, 3));
    pending_words.push_back(make_word(CMD_QUERY,  0, 0, 0, 0));
    pending_words.push_back(make_word(CMD_QUERY,  0, 0, LEAVES + 1, 2047));
    pending_words.push_back(make_word(CMD_QUERY,  2047, 30'h3FFF_FFFF, 0, 1));
    pending_words.push_back(make_word(CMD_UPDATE, 1, 999, 2047, 2047));
    pending_words.push_back(make_word(CMD_QUERY,  0, 0, 1, 3));

    // hold off until the directed words are fully answered
    while (pending_words.size() > 0 || in_valid_i || expected_minima.size() > 0)
      @(posedge clk_i);
    repeat (30) @(posedge clk_i);

    @(negedge clk_i);
    for (int i = 0; i < 1400; i++) pending_words.push_back(random_word());

    while (pending_words.size() > 0 || in_valid_i || expected_minima.size() > 0)
      @(posedge clk_i);
    repeat (30) @(posedge clk_i);

    if (error_count == 0 && expected_minima.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

  // run limit
  initial begin
    #20ms;
    $display("%0t: run limit reached with %0d results outstanding",
             $time, expected_minima.size());
    $display("*** FAILED ***");
    $finish;
  end

endmodule

// ===== range_min_segment_tree.f =====
hw/rtl/rmst_pkg.sv
hw/rtl/range_min_segment_tree.sv
dv/tb_range_min_segment_tree.sv
